// ===== hw/rtl/arpc_pkg.sv =====
// Shared types, sizes and codes for the ARP cache and responder.
// No dependencies; every other file of the block imports this package.
package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int OP_W   = 2;
   localparam int STAT_W = 3;
   localparam int CSR_W  = 48;
   localparam int CSR_IDX_W = 1;

   localparam logic [IP_W-1:0] OWN_IP_RESET = 32'h0F02000A;
   localparam logic [15:0]     ARP_OPER_REQUEST = 16'd1;

   // operation codes
   localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
   localparam logic [STAT_W-1:0] ST_REPLY = 3'd1;
   localparam logic [STAT_W-1:0] ST_HIT   = 3'd2;
   localparam logic [STAT_W-1:0] ST_MISS  = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'd1;

   // table write request
   typedef struct packed {
      logic             ip_en;
      logic             mac_en;
      logic [IDX_W-1:0] addr;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } tbl_wr_type;

   // latched input item
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IP_W-1:0]  sender_ip;
      logic [MAC_W-1:0] sender_mac;
      logic [IP_W-1:0]  target_ip;
      logic [15:0]      arp_oper;
      logic [15:0]      hw_type;
      logic [15:0]      proto_type;
      logic [7:0]       hw_len;
      logic [7:0]       proto_len;
   } item_type;

endpackage

// ===== hw/rtl/arpc_table.sv =====
// Entry storage: IP and MAC arrays, one write port, one registered read port.
// Depends on arpc_pkg.
module arpc_table
   import arpc_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IP_W-1:0]  rd_ip,
   output logic [MAC_W-1:0] rd_mac,
   input  tbl_wr_type       wr
);

   logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
   logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
   logic [IP_W-1:0]  rd_ip_ff;
   logic [MAC_W-1:0] rd_mac_ff;

   always_ff @(posedge clock) begin
      if (wr.ip_en) begin
         ip_mem[wr.addr] <= wr.ip;
      end
      if (wr.mac_en) begin
         mac_mem[wr.addr] <= wr.mac;
      end
      rd_ip_ff  <= ip_mem[rd_addr];
      rd_mac_ff <= mac_mem[rd_addr];
   end

   assign rd_ip  = rd_ip_ff;
   assign rd_mac = rd_mac_ff;

endmodule

// ===== hw/rtl/arp_cache_and_responder_unit.sv =====
// ARP cache and request responder, top level.
// Depends on arpc_pkg and arpc_table.
//
// Usage:
//  - Input transfer: start high while busy is low; the req_ ports carry the item.
//    op 0 is a received ARP frame, op 1 adds an entry, op 2 looks one up.
//  - Exactly one result per item: rsp_strobe is high for one cycle with the
//    rsp_ ports valid. The receiver cannot stall; every strobe is a transfer.
//  - Add and unused op codes answer in the cycle after the transfer and
//    busy never rises, so an item may follow every cycle.
//    Frame and lookup scan the table linearly, one read of the table memory
//    per cycle with the compare in the cycle after that read; the result is
//    registered from the first hit, or from the miss once every entry held is compared.
//    busy is high from the cycle after the transfer to the cycle before the
//    strobe, so the next item may start in the strobe cycle.
//  - The scan stops at the first match, which is the lowest index.
//  - csr_we writes own_ip (index 0); a write to index 1 (own_mac) is ignored.
//    Write only while idle; the block does not enforce this. own_mac belongs
//    to reply assembly outside this block and is not held here.
//  - Reset (synchronous): empty table, own_ip back to 0x0F02000A, idle.
//    Table contents are not cleared; only entries below the count are read.
module arp_cache_and_responder_unit
   import arpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_op,
   input  logic [IP_W-1:0]      req_sender_ip,
   input  logic [MAC_W-1:0]     req_sender_mac,
   input  logic [IP_W-1:0]      req_target_ip,
   input  logic [15:0]          req_arp_oper,
   input  logic [15:0]          req_hw_type,
   input  logic [15:0]          req_proto_type,
   input  logic [7:0]           req_hw_len,
   input  logic [7:0]           req_proto_len,
   output logic                 rsp_strobe,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [MAC_W-1:0]     rsp_mac_out,
   output logic [IP_W-1:0]      rsp_reply_sender_ip,
   output logic [IP_W-1:0]      rsp_reply_target_ip,
   output logic [15:0]          rsp_reply_hw_type,
   output logic [15:0]          rsp_reply_proto_type,
   output logic [7:0]           rsp_reply_hw_len,
   output logic [7:0]           rsp_reply_proto_len,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;   // entries held
   logic [CNT_W-1:0]  scan_ff, scan_in;     // next index to read
   logic              pend_ff, pend_in;     // a read is in flight
   logic [IDX_W-1:0]  pidx_ff, pidx_in;     // index of that read
   logic [IP_W-1:0]   own_ip_ff;
   item_type          item_ff;

   logic              strobe_ff, strobe_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [IP_W-1:0]   rsip_ff, rsip_in;
   logic [IP_W-1:0]   rtip_ff, rtip_in;
   logic [15:0]       rhwt_ff, rhwt_in;
   logic [15:0]       rprt_ff, rprt_in;
   logic [7:0]        rhwl_ff, rhwl_in;
   logic [7:0]        rprl_ff, rprl_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [IP_W-1:0]   rd_ip;
   logic [MAC_W-1:0]  rd_mac;
   tbl_wr_type        wr;

   logic              tbl_full;
   logic              hit;
   logic              miss;
   logic              to_me;

   arpc_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac),
      .wr      (wr)
   );

   assign tbl_full = (count_ff == CNT_W'(TABLE_ENTRIES));
   // compare runs in the cycle after the read
   assign hit   = pend_ff && (rd_ip == item_ff.sender_ip);
   assign miss  = !hit && (scan_ff == count_ff);
   assign to_me = (item_ff.target_ip == own_ip_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      strobe_in = 1'b0;
      status_in = ST_DONE;
      mac_in    = '0;
      rsip_in   = '0;
      rtip_in   = '0;
      rhwt_in   = '0;
      rprt_in   = '0;
      rhwl_in   = '0;
      rprl_in   = '0;
      rd_addr   = scan_ff[IDX_W-1:0];
      wr        = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_FRAME, OP_LOOKUP: begin
                     state_in = S_SEARCH;
                     scan_in  = '0;
                  end
                  OP_ADD: begin
                     // append straight from the ports, no duplicate check
                     strobe_in = 1'b1;
                     if (tbl_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr.ip_en  = 1'b1;
                        wr.mac_en = 1'b1;
                        wr.addr   = count_ff[IDX_W-1:0];
                        wr.ip     = req_sender_ip;
                        wr.mac    = req_sender_mac;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (scan_ff != count_ff) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (hit || miss) begin
               state_in  = S_IDLE;
               pend_in   = 1'b0;
               strobe_in = 1'b1;
               if (item_ff.op == OP_LOOKUP) begin
                  if (hit) begin
                     status_in = ST_HIT;
                     mac_in    = rd_mac;
                  end else begin
                     status_in = ST_MISS;
                  end
               end else begin
                  if (hit) begin
                     // refresh the MAC of the first matching entry
                     wr.mac_en = 1'b1;
                     wr.addr   = pidx_ff;
                     wr.mac    = item_ff.sender_mac;
                  end
                  if (to_me) begin
                     if (!hit && !tbl_full) begin
                        wr.ip_en  = 1'b1;
                        wr.mac_en = 1'b1;
                        wr.addr   = count_ff[IDX_W-1:0];
                        wr.ip     = item_ff.sender_ip;
                        wr.mac    = item_ff.sender_mac;
                        count_in  = count_ff + 1'b1;
                     end
                     if (item_ff.arp_oper == ARP_OPER_REQUEST) begin
                        // a reply wins over a dropped insert
                        status_in = ST_REPLY;
                        mac_in    = item_ff.sender_mac;
                        rsip_in   = item_ff.target_ip;
                        rtip_in   = item_ff.sender_ip;
                        rhwt_in   = item_ff.hw_type;
                        rprt_in   = item_ff.proto_type;
                        rhwl_in   = item_ff.hw_len;
                        rprl_in   = item_ff.proto_len;
                     end else if (!hit && tbl_full) begin
                        status_in = ST_FULL;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      pidx_ff   <= pidx_in;
      status_ff <= status_in;
      mac_ff    <= mac_in;
      rsip_ff   <= rsip_in;
      rtip_ff   <= rtip_in;
      rhwt_ff   <= rhwt_in;
      rprt_ff   <= rprt_in;
      rhwl_ff   <= rhwl_in;
      rprl_ff   <= rprl_in;
   end

   // item capture on an input transfer
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         item_ff.op         <= req_op;
         item_ff.sender_ip  <= req_sender_ip;
         item_ff.sender_mac <= req_sender_mac;
         item_ff.target_ip  <= req_target_ip;
         item_ff.arp_oper   <= req_arp_oper;
         item_ff.hw_type    <= req_hw_type;
         item_ff.proto_type <= req_proto_type;
         item_ff.hw_len     <= req_hw_len;
         item_ff.proto_len  <= req_proto_len;
      end
   end

   // config: own_ip only; own_mac is consumed by external reply assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= OWN_IP_RESET;
      end else if (csr_we && csr_index == CSR_OWN_IP) begin
         own_ip_ff <= csr_wdata[IP_W-1:0];
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_mac_out          = mac_ff;
   assign rsp_reply_sender_ip  = rsip_ff;
   assign rsp_reply_target_ip  = rtip_ff;
   assign rsp_reply_hw_type    = rhwt_ff;
   assign rsp_reply_proto_type = rprt_ff;
   assign rsp_reply_hw_len     = rhwl_ff;
   assign rsp_reply_proto_len  = rprl_ff;

endmodule

// ===== hw/rtl/arpc_checker.sv =====
// Port-level checks for the ARP cache and responder, bound to the top level.
// Depends on arpc_pkg and arp_cache_and_responder_unit.
module arpc_checker
   import arpc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [OP_W-1:0]      req_op,
   input logic                 rsp_strobe,
   input logic [STAT_W-1:0]    rsp_status,
   input logic [MAC_W-1:0]     rsp_mac_out,
   input logic [IP_W-1:0]      rsp_reply_sender_ip,
   input logic [IP_W-1:0]      rsp_reply_target_ip
);

   // add answers in the next cycle without raising busy
   a_add_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == OP_ADD |=> rsp_strobe && !busy)
      else $error("add transfer not answered in the next cycle");

   // a miss carries no MAC
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_MISS |-> rsp_mac_out == '0)
      else $error("lookup miss with nonzero MAC");

   // reply addresses only appear with a reply
   a_noreply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_REPLY |->
         rsp_reply_sender_ip == '0 && rsp_reply_target_ip == '0)
      else $error("reply addresses without a reply");

   // no status code beyond table full
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= ST_FULL)
      else $error("undefined status code");

   // reset leaves the block idle with no pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind arp_cache_and_responder_unit arpc_checker u_arpc_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_op              (req_op),
   .rsp_strobe          (rsp_strobe),
   .rsp_status          (rsp_status),
   .rsp_mac_out         (rsp_mac_out),
   .rsp_reply_sender_ip (rsp_reply_sender_ip),
   .rsp_reply_target_ip (rsp_reply_target_ip)
);
